// ----- sv/blr_pkg.sv -----
// Shared constants and types of the letterbox bilinear scaler.
package blr_pkg;

  localparam int SRC_W      = 128;
  localparam int SRC_H      = 128;
  localparam int DST_MAX    = 256;
  localparam int NCH        = 3;
  localparam int XW         = $clog2(SRC_W);
  localparam int YW         = $clog2(SRC_H);
  localparam int BANK_DEPTH = (SRC_W / 2) * (SRC_H / 2);
  localparam int BANK_AW    = (XW - 1) + (YW - 1);
  localparam int STEP_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int PIX_W      = 8 * NCH;

  typedef enum logic [2:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_SCL_W  = 3'd2,
    REG_SCL_H  = 3'd3,
    REG_CNV_W  = 3'd4,
    REG_CNV_H  = 3'd5,
    REG_BG     = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_e;

endpackage

// ----- sv/bilinear_letterbox_resize.sv -----
// Top level of the letterbox bilinear scaler with its banked source frame store.
//
// Usage: the input channel carries load and request transactions (cmd_i 0 or 1).
// A load writes one three-channel source pixel at (pos_x_i, pos_y_i); it gives no
// output. A request gives one output transaction: the bilinear pixel inside the
// scaled area, the background value elsewhere on the canvas, or outside_o set
// with zero pixels beyond the canvas.
// Throughput: one transaction per cycle unless a receiver stall or a running
// divider holds the input. The source store is split into four parity banks
// (row parity, column parity), so the four neighbours of a pixel are read in
// the same cycle. A request passes five pipe stages plus the output register
// before out_valid_o rises. Registers sit on an APB port; write them only while
// the block is idle. A write of a width register restarts the horizontal step
// divider, a write of a height register the vertical one; input stall stays high
// while a divider runs. After reset the dividers run once before the first
// transaction is taken.
// A stall from the receiver while a result is held freezes the whole pipe;
// input stall follows it in the same cycle, so nothing is lost or repeated.
module bilinear_letterbox_resize
  import blr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  chan0_i,
  input  logic [7:0]  chan1_i,
  input  logic [7:0]  chan2_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pix0_o,
  output logic [7:0]  pix1_o,
  output logic [7:0]  pix2_o,
  output logic        outside_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [7:0] src_w_q, src_h_q, bg_q;
  logic [8:0] scl_w_q, scl_h_q, cnv_w_q, cnv_h_q;
  reg_idx_e   reg_idx;
  logic       cfg_we;
  logic       div_h_start, div_v_start, div_h_busy, div_v_busy;
  logic [STEP_W-1:0] step_h, step_v;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 8'd128;
      src_h_q <= 8'd128;
      scl_w_q <= 9'd128;
      scl_h_q <= 9'd128;
      cnv_w_q <= 9'd256;
      cnv_h_q <= 9'd256;
      bg_q    <= 8'd0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SRC_W: src_w_q <= pwdata[7:0];
        REG_SRC_H: src_h_q <= pwdata[7:0];
        REG_SCL_W: scl_w_q <= pwdata[8:0];
        REG_SCL_H: scl_h_q <= pwdata[8:0];
        REG_CNV_W: cnv_w_q <= pwdata[8:0];
        REG_CNV_H: cnv_h_q <= pwdata[8:0];
        REG_BG:    bg_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_W: prdata = {24'd0, src_w_q};
      REG_SRC_H: prdata = {24'd0, src_h_q};
      REG_SCL_W: prdata = {23'd0, scl_w_q};
      REG_SCL_H: prdata = {23'd0, scl_h_q};
      REG_CNV_W: prdata = {23'd0, cnv_w_q};
      REG_CNV_H: prdata = {23'd0, cnv_h_q};
      REG_BG:    prdata = {24'd0, bg_q};
      default:   prdata = 32'd0;
    endcase
  end

  // Restart the step divider of an axis on a write of one of its size registers.
  assign div_h_start = cfg_we && (reg_idx == REG_SRC_W || reg_idx == REG_SCL_W);
  assign div_v_start = cfg_we && (reg_idx == REG_SRC_H || reg_idx == REG_SCL_H);

  blr_step_div u_div_h (
    .clk_i, .rst_ni, .start_i(div_h_start), .src_i(src_w_q), .scaled_i(scl_w_q),
    .busy_o(div_h_busy), .step_o(step_h)
  );
  blr_step_div u_div_v (
    .clk_i, .rst_ni, .start_i(div_v_start), .src_i(src_h_q), .scaled_i(scl_h_q),
    .busy_o(div_v_busy), .step_o(step_v)
  );

  // ---------------- pipe control ----------------
  logic adv, in_acc;
  logic out_valid_q;

  // Advance every stage unless a finished result is held by the receiver.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv || div_h_busy || div_v_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Effective sizes.
  logic [8:0]    cnv_w_eff, cnv_h_eff;
  logic [XW-1:0] lim_x;
  logic [YW-1:0] lim_y;

  assign cnv_w_eff = (cnv_w_q > 9'(DST_MAX)) ? 9'(DST_MAX) : cnv_w_q;
  assign cnv_h_eff = (cnv_h_q > 9'(DST_MAX)) ? 9'(DST_MAX) : cnv_h_q;
  assign lim_x = (src_w_q == 8'd0) ? '0 :
                 ({1'b0, src_w_q} > 9'(SRC_W)) ? XW'(SRC_W - 1) : XW'(src_w_q - 8'd1);
  assign lim_y = (src_h_q == 8'd0) ? '0 :
                 ({1'b0, src_h_q} > 9'(SRC_H)) ? YW'(SRC_H - 1) : YW'(src_h_q - 8'd1);

  // ---------------- stage 1: capture ----------------
  logic             v1_q, cmd1_q;
  logic [7:0]       x1_q, y1_q;
  logic [PIX_W-1:0] dat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_acc) begin
      cmd1_q <= cmd_i;
      x1_q   <= pos_x_i;
      y1_q   <= pos_y_i;
      dat1_q <= {chan2_i, chan1_i, chan0_i};
    end
  end

  // ---------------- stage 2: source coordinate ----------------
  logic             v2_q, cmd2_q, out2_q, area2_q, ldok2_q;
  logic [7:0]       x2_q, y2_q;
  logic [PIX_W-1:0] dat2_q;
  logic [32:0]      ux2_q, uy2_q, ux2_d, uy2_d;
  logic [32:0]      prod_x, prod_y;

  // (p + 0.5) * step - 0.5 + 1.0, the product halved with rounding.
  assign prod_x = 33'({x1_q, 1'b1}) * 33'(step_h);
  assign prod_y = 33'({y1_q, 1'b1}) * 33'(step_v);
  assign ux2_d  = 33'((34'(prod_x) + 34'd1) >> 1) + 33'd32768;
  assign uy2_d  = 33'((34'(prod_y) + 34'd1) >> 1) + 33'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd2_q  <= cmd1_q;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      dat2_q  <= dat1_q;
      ux2_q   <= ux2_d;
      uy2_q   <= uy2_d;
      out2_q  <= ({1'b0, x1_q} >= cnv_w_eff) || ({1'b0, y1_q} >= cnv_h_eff);
      area2_q <= ({1'b0, x1_q} < scl_w_q) && ({1'b0, y1_q} < scl_h_q);
      ldok2_q <= (9'(x1_q) < 9'(SRC_W)) && (9'(y1_q) < 9'(SRC_H));
    end
  end

  // ---------------- stage 3: neighbours and frame store ----------------
  logic [16:0]       bx, by, ax, ay;
  logic [XW-1:0]     x0_d, x1n_d;
  logic [YW-1:0]     y0_d, y1n_d;
  logic              v3_q, cmd3_q, out3_q, area3_q, ldok3_q;
  logic [XW-1:0]     ldx3_q, x0_q, x1n_q;
  logic [YW-1:0]     ldy3_q, y0_q, y1n_q;
  logic [PIX_W-1:0]  dat3_q;
  logic [FRAC_W-1:0] fx3_q, fy3_q;

  assign bx = ux2_q[32:16];
  assign by = uy2_q[32:16];
  assign ax = (bx == 17'd0) ? 17'd0 : bx - 17'd1;
  assign ay = (by == 17'd0) ? 17'd0 : by - 17'd1;
  // Clamp each neighbour to the last source column or row.
  assign x0_d  = (ax > 17'(lim_x)) ? lim_x : XW'(ax);
  assign x1n_d = (bx > 17'(lim_x)) ? lim_x : XW'(bx);
  assign y0_d  = (ay > 17'(lim_y)) ? lim_y : YW'(ay);
  assign y1n_d = (by > 17'(lim_y)) ? lim_y : YW'(by);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd3_q  <= cmd2_q;
      out3_q  <= out2_q;
      area3_q <= area2_q;
      ldok3_q <= ldok2_q;
      ldx3_q  <= XW'(x2_q);
      ldy3_q  <= YW'(y2_q);
      dat3_q  <= dat2_q;
      fx3_q   <= ux2_q[FRAC_W-1:0];
      fy3_q   <= uy2_q[FRAC_W-1:0];
      x0_q    <= x0_d;
      x1n_q   <= x1n_d;
      y0_q    <= y0_d;
      y1n_q   <= y1n_d;
    end
  end

  // Four parity banks: bank index is {row parity, column parity}.
  logic               ram_we   [4];
  logic [BANK_AW-1:0] ram_ra   [4];
  logic [PIX_W-1:0]   ram_rd   [4];
  logic [BANK_AW-1:0] ram_wa;
  logic               load_wr;

  assign load_wr = adv && v3_q && !cmd3_q && ldok3_q;
  assign ram_wa  = {ldy3_q[YW-1:1], ldx3_q[XW-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] cx;
    logic [YW-1:0] ry;
    assign cx = (x0_q[0] == 1'(b % 2)) ? x0_q : x1n_q;
    assign ry = (y0_q[0] == 1'(b / 2)) ? y0_q : y1n_q;
    assign ram_ra[b] = {ry[YW-1:1], cx[XW-1:1]};
    assign ram_we[b] = load_wr && (ldx3_q[0] == 1'(b % 2)) && (ldy3_q[0] == 1'(b / 2));

    blr_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk_i,
      .we_i   (ram_we[b]),
      .waddr_i(ram_wa),
      .wdata_i(dat3_q),
      .re_i   (adv),
      .raddr_i(ram_ra[b]),
      .rdata_o(ram_rd[b])
    );
  end

  // Corner weights, each product rounded to Q1.16.
  logic [16:0] ifx, ify;
  logic [16:0] w_d [4];
  logic [16:0] w4_q [4];
  logic        v4_q, cmd4_q, out4_q, area4_q;
  logic [1:0]  sel4_q [4];

  assign ifx = 17'h10000 - 17'(fx3_q);
  assign ify = 17'h10000 - 17'(fy3_q);
  assign w_d[0] = 17'((34'(ifx)   * 34'(ify)   + 34'd32768) >> 16);
  assign w_d[1] = 17'((34'(fx3_q) * 34'(ify)   + 34'd32768) >> 16);
  assign w_d[2] = 17'((34'(ifx)   * 34'(fy3_q) + 34'd32768) >> 16);
  assign w_d[3] = 17'((34'(fx3_q) * 34'(fy3_q) + 34'd32768) >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd4_q    <= cmd3_q;
      out4_q    <= out3_q;
      area4_q   <= area3_q;
      w4_q      <= w_d;
      sel4_q[0] <= {y0_q[0],  x0_q[0]};
      sel4_q[1] <= {y0_q[0],  x1n_q[0]};
      sel4_q[2] <= {y1n_q[0], x0_q[0]};
      sel4_q[3] <= {y1n_q[0], x1n_q[0]};
    end
  end

  // ---------------- stage 4: weight times sample ----------------
  logic [PIX_W-1:0] smp [4];
  logic [24:0]      prod5_q [NCH][4];
  logic             v5_q, cmd5_q, out5_q, area5_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      smp[k] = ram_rd[sel4_q[k]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd5_q  <= cmd4_q;
      out5_q  <= out4_q;
      area5_q <= area4_q;
      for (int c = 0; c < NCH; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod5_q[c][k] <= 25'(w4_q[k]) * 25'(smp[k][8*c +: 8]);
        end
      end
    end
  end

  // ---------------- stage 5: sum, round, clamp, select ----------------
  logic [PIX_W-1:0] pix_d, pix_q;
  logic             outside_q;
  logic [26:0]      acc  [NCH];
  logic [10:0]      rnd  [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      acc[c] = 27'(prod5_q[c][0]) + 27'(prod5_q[c][1]) + 27'(prod5_q[c][2])
             + 27'(prod5_q[c][3]) + 27'd32768;
      rnd[c] = acc[c][26:16];
      if (out5_q) begin
        pix_d[8*c +: 8] = 8'd0;
      end else if (!area5_q) begin
        pix_d[8*c +: 8] = bg_q;
      end else begin
        pix_d[8*c +: 8] = (rnd[c] > 11'd255) ? 8'd255 : rnd[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v5_q && cmd5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q     <= pix_d;
      outside_q <= out5_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix0_o      = pix_q[7:0];
  assign pix1_o      = pix_q[15:8];
  assign pix2_o      = pix_q[23:16];
  assign outside_o   = outside_q;

  // ---------------- assertions ----------------
  a_busy_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_h_busy || div_v_busy) |-> in_stall_o)
    else $error("input taken while a step divider runs");

  a_request_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v5_q && cmd5_q) |=> out_valid_o)
    else $error("request lost before the output register");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_o) |-> (pix0_o == 8'd0 && pix1_o == 8'd0 && pix2_o == 8'd0))
    else $error("outside pixel carries nonzero channels");

  a_write_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_wr |-> (v3_q && !cmd3_q && adv))
    else $error("frame store written by a request or while stalled");

endmodule

// ----- sv/blr_ram.sv -----
// Generic simple dual-port RAM with registered read.
module blr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/blr_step_div.sv -----
// Restoring divider that forms one Q8.16 scale step, one quotient bit a cycle.
module blr_step_div
  import blr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        src_i,
  input  logic [8:0]        scaled_i,
  output logic              busy_o,
  output logic [STEP_W-1:0] step_o
);

  logic              busy_q, busy_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [8:0]        rem_q, rem_d;
  logic [STEP_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] dividend;
  logic [9:0]        trial;
  logic              qbit;

  assign dividend = {src_i, 16'd0};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    trial  = {rem_q, dividend[5'(STEP_W - 1) - cnt_q]};
    qbit   = (trial >= {1'b0, scaled_i});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = qbit ? 9'(trial - {1'b0, scaled_i}) : 9'(trial);
      quot_d = {quot_q[STEP_W-2:0], qbit};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'(STEP_W - 1)) begin
        busy_d = 1'b0;
        step_d = (scaled_i == 9'd0) ? '0 : quot_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
      step_q <= step_d;
    end
  end

  assign busy_o = busy_q;
  assign step_o = step_q;

endmodule

// ----- sim/bilinear_letterbox_resize_tb.sv -----
// Self-checking testbench for the letterbox bilinear scaler.
`timescale 1ns / 100ps

module bilinear_letterbox_resize_tb;
  import blr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic       outside;
  } pixel_t;

  typedef struct {
    logic       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       typed;
    pixel_t     want;
  } row_t;

  // DUT signals
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [7:0]  pos_x_i = '0, pos_y_i = '0;
  logic [7:0]  chan0_i = '0, chan1_i = '0, chan2_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  pix0_o, pix1_o, pix2_o;
  logic        outside_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bilinear_letterbox_resize uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scaler shadow state
  logic [23:0] frame_store [SRC_W*SRC_H];
  logic [23:0] step_h, step_v;
  bit          steps_stale;
  int unsigned src_w_reg, src_h_reg, scl_w_reg, scl_h_reg, cnv_w_reg, cnv_h_reg, bg_reg;

  pixel_t pending_pixels [$];
  int     mismatches;
  int     cycles;
  int     stall_left;
  bit     quiet;

  function automatic logic [23:0] calc_step(int unsigned src, int unsigned scl);
    longint unsigned q;
    if (scl == 0) return '0;
    q = (longint'(src) << 16) / scl;
    return q[23:0];
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Map a destination coordinate to a neighbour pair and Q0.16 fraction.
  task automatic map_coord(input int unsigned p, input logic [23:0] step,
                           input int unsigned size, output int unsigned i0,
                           output int unsigned i1, output longint unsigned frac);
    longint unsigned u, base, a, b;
    u = ((((2*longint'(p) + 1) * step) + 1) >> 1) + 32768;
    base = u >> 16;
    frac = u & 16'hFFFF;
    a = (base == 0) ? 0 : base - 1;
    b = base;
    if (a > size - 1) a = size - 1;
    if (b > size - 1) b = size - 1;
    i0 = 32'(a);
    i1 = 32'(b);
  endtask

  function automatic longint unsigned wprod(longint unsigned a, longint unsigned b);
    return (a * b + 32768) >> 16;
  endfunction

  // Work out the destination pixel of one request transaction.
  task automatic resample(input int unsigned x, input int unsigned y, output pixel_t r);
    int unsigned cw, ch, sw, sh, x0, x1, y0, y1;
    longint unsigned fx, fy, w00, w01, w10, w11, acc;
    logic [23:0] s00, s01, s10, s11;
    if (steps_stale) begin
      step_h = calc_step(src_w_reg, scl_w_reg);
      step_v = calc_step(src_h_reg, scl_h_reg);
      steps_stale = 0;
    end
    cw = (cnv_w_reg > DST_MAX) ? DST_MAX : cnv_w_reg;
    ch = (cnv_h_reg > DST_MAX) ? DST_MAX : cnv_h_reg;
    r = '0;
    if (x >= cw || y >= ch) begin
      r.outside = 1'b1;
    end else if (x < scl_w_reg && y < scl_h_reg) begin
      sw = clamp_dim(src_w_reg, SRC_W);
      sh = clamp_dim(src_h_reg, SRC_H);
      map_coord(x, step_h, sw, x0, x1, fx);
      map_coord(y, step_v, sh, y0, y1, fy);
      w00 = wprod(65536 - fx, 65536 - fy);
      w01 = wprod(fx, 65536 - fy);
      w10 = wprod(65536 - fx, fy);
      w11 = wprod(fx, fy);
      s00 = frame_store[y0*SRC_W + x0];
      s01 = frame_store[y0*SRC_W + x1];
      s10 = frame_store[y1*SRC_W + x0];
      s11 = frame_store[y1*SRC_W + x1];
      for (int c = 0; c < 3; c++) begin
        acc = w00*s00[8*c +: 8] + w01*s01[8*c +: 8] + w10*s10[8*c +: 8]
            + w11*s11[8*c +: 8];
        acc = (acc + 32768) >> 16;
        if (acc > 255) acc = 255;
        case (c)
          0: r.p0 = acc[7:0];
          1: r.p1 = acc[7:0];
          default: r.p2 = acc[7:0];
        endcase
      end
    end else begin
      r.p0 = bg_reg[7:0];
      r.p1 = bg_reg[7:0];
      r.p2 = bg_reg[7:0];
    end
  endtask

  // Drive one input transaction; predict at the edge that accepts it.
  task automatic send_item(input row_t it);
    int gap;
    pixel_t r;
    gap = quiet ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    pos_x_i <= it.x;
    pos_y_i <= it.y;
    chan0_i <= it.c0;
    chan1_i <= it.c1;
    chan2_i <= it.c2;
    // hold the payload until the block takes it
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    if (it.cmd == 1'b0) begin
      if (it.x < SRC_W && it.y < SRC_H)
        frame_store[it.y*SRC_W + it.x] = {it.c2, it.c1, it.c0};
      steps_stale = 1;
    end else begin
      resample(it.x, it.y, r);
      pending_pixels.push_back(it.typed ? it.want : r);
    end
  endtask

  task automatic end_stream();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait for every pixel in flight, then let loads trickle out of the pipe.
  task automatic drain();
    end_stream();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_W: src_w_reg = val & 8'hFF;
      REG_SRC_H: src_h_reg = val & 8'hFF;
      REG_SCL_W: scl_w_reg = val & 9'h1FF;
      REG_SCL_H: scl_h_reg = val & 9'h1FF;
      REG_CNV_W: cnv_w_reg = val & 9'h1FF;
      REG_CNV_H: cnv_h_reg = val & 9'h1FF;
      REG_BG:    bg_reg = val & 8'hFF;
      default: ;
    endcase
    steps_stale = 1;
  endtask

  task automatic configure(input int unsigned sw, input int unsigned sh,
                           input int unsigned scw, input int unsigned sch,
                           input int unsigned cw, input int unsigned ch,
                           input int unsigned bg);
    reg_write(REG_SRC_W, sw);
    reg_write(REG_SRC_H, sh);
    reg_write(REG_SCL_W, scw);
    reg_write(REG_SCL_H, sch);
    reg_write(REG_CNV_W, cw);
    reg_write(REG_CNV_H, ch);
    reg_write(REG_BG, bg);
  endtask

  function automatic row_t mk(logic cmd, int x, int y, int c0, int c1, int c2,
                              logic typed = 0, pixel_t want = '0);
    row_t r;
    r.cmd = cmd; r.x = 8'(x); r.y = 8'(y);
    r.c0 = 8'(c0); r.c1 = 8'(c1); r.c2 = 8'(c2);
    r.typed = typed; r.want = want;
    return r;
  endfunction

  // Check each output transaction against the oldest expected pixel.
  always @(posedge clk_i) begin
    pixel_t w, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{pix0_o, pix1_o, pix2_o, outside_o};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction %h", got);
      end else begin
        w = pending_pixels.pop_front();
        if (got !== w) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch: expected p0=%0d p1=%0d p2=%0d out=%b, ",
                      "got p0=%0d p1=%0d p2=%0d out=%b"},
                     w.p0, w.p1, w.p2, w.outside, got.p0, got.p1, got.p2, got.outside);
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 16);
    end
  end

  // Receiver back-pressure: hold stall for the drawn number of cycles.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bilinear_letterbox_resize_tb: errors");
      $finish;
    end
  end

  // Fill the whole effective source area so no request reads an empty entry.
  task automatic fill_source();
    int unsigned sw, sh;
    sw = clamp_dim(src_w_reg, SRC_W);
    sh = clamp_dim(src_h_reg, SRC_H);
    for (int y = 0; y < sh; y++)
      for (int x = 0; x < sw; x++)
        send_item(mk(0, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255)));
  endtask

  task automatic random_phase(input int n, input bit hold_off);
    int unsigned cw, ch, sw, sh;
    row_t it;
    cw = (cnv_w_reg > DST_MAX) ? DST_MAX : cnv_w_reg;
    ch = (cnv_h_reg > DST_MAX) ? DST_MAX : cnv_h_reg;
    sw = clamp_dim(src_w_reg, SRC_W);
    sh = clamp_dim(src_h_reg, SRC_H);
    for (int i = 0; i < n; i++) begin
      quiet = ((i / 8) % 3) == 2;
      if (hold_off && i == n / 2) begin
        // pause the sender until every pixel has come back
        end_stream();
        while (pending_pixels.size() != 0) @(posedge clk_i);
      end
      it = mk(1, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15) begin
        it.cmd = 0;
        if ($urandom_range(0, 1)) begin
          it.x = 8'($urandom_range(0, sw - 1));
          it.y = 8'($urandom_range(0, sh - 1));
        end else begin
          it.x = 8'($urandom_range(0, 255));
          it.y = 8'($urandom_range(0, 255));
        end
      end else if ($urandom_range(0, 99) < 70) begin
        it.x = 8'($urandom_range(0, (cw + 2 > 255) ? 255 : cw + 2));
        it.y = 8'($urandom_range(0, (ch + 2 > 255) ? 255 : ch + 2));
      end else begin
        it.x = 8'($urandom_range(0, 255));
        it.y = 8'($urandom_range(0, 255));
      end
      send_item(it);
    end
    quiet = 0;
  endtask

  row_t table_rows [$];

  initial begin
    src_w_reg = 128; src_h_reg = 128; scl_w_reg = 128; scl_h_reg = 128;
    cnv_w_reg = 256; cnv_h_reg = 256; bg_reg = 0;
    step_h = '0; step_v = '0; steps_stale = 1;
    mismatches = 0; cycles = 0; stall_left = 0; quiet = 0;

    // rows 0..1 run on reset settings, the rest on a 2x2 source into 4x4
    table_rows = '{
      mk(1, 200, 200, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b0}),
      mk(1, 255, 255, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b0}),
      mk(0, 0, 0, 0, 0, 0),
      mk(0, 1, 0, 255, 255, 255),
      mk(0, 0, 1, 255, 0, 128),
      mk(0, 1, 1, 0, 255, 1),
      mk(0, 200, 5, 9, 9, 9),
      mk(0, 5, 130, 9, 9, 9),
      mk(0, 255, 255, 9, 9, 9),
      mk(1, 0, 0, 0, 0, 0),
      mk(1, 3, 3, 0, 0, 0),
      mk(1, 1, 2, 0, 0, 0),
      mk(1, 2, 1, 0, 0, 0),
      mk(1, 7, 5, 0, 0, 0, 1, '{8'd255, 8'd255, 8'd255, 1'b0}),
      mk(1, 4, 0, 0, 0, 0, 1, '{8'd255, 8'd255, 8'd255, 1'b0}),
      mk(1, 0, 4, 0, 0, 0, 1, '{8'd255, 8'd255, 8'd255, 1'b0}),
      mk(1, 8, 0, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}),
      mk(1, 0, 6, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}),
      mk(1, 255, 255, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1}),
      mk(1, 255, 0, 0, 0, 0, 1, '{8'd0, 8'd0, 8'd0, 1'b1})
    };

    // hold reset, then release it at a falling edge
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) begin
      if (i == 2) begin
        drain();
        configure(2, 2, 4, 4, 8, 6, 255);
      end
      send_item(table_rows[i]);
    end

    // random phases across settings, extremes included
    drain(); configure(4, 3, 9, 7, 16, 12, 17);        fill_source(); random_phase(26, 0);
    drain(); configure(128, 1, 256, 3, 256, 256, 0);   fill_source(); random_phase(26, 1);
    drain(); configure(1, 20, 1, 256, 511, 300, 255);  fill_source(); random_phase(26, 0);
    drain(); configure(255, 1, 200, 5, 1, 1, 90);      fill_source(); random_phase(26, 0);
    drain(); configure(0, 0, 0, 0, 256, 256, 200);     fill_source(); random_phase(26, 0);
    drain(); configure(7, 5, 3, 2, 50, 40, 33);        fill_source(); random_phase(26, 0);

    drain();
    if (pending_pixels.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("bilinear_letterbox_resize_tb: clean");
    end else begin
      $display("bilinear_letterbox_resize_tb: errors");
    end
    $finish;
  end

endmodule
